[rtl/rhc_pkg.sv]
// rhc_pkg: shared types and constants of the rgb/hsv color converter
// used by the front, queue and back modules; no dependencies
package rhc_pkg;

    localparam logic ACT_HSV2RGB = 1'b0;
    localparam logic ACT_RGB2HSV = 1'b1;

    localparam int unsigned HUE_SPAN  = 43;
    localparam int unsigned HUE_BASE_G = 85;
    localparam int unsigned HUE_BASE_B = 171;
    localparam int unsigned REGIONS   = 6;

    localparam int unsigned SAT_QW    = 8;
    localparam int unsigned HUE_QW    = 6;
    localparam int unsigned PIPE_LAST = SAT_QW;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_sel;

    typedef struct packed {
        logic       action;
        logic [2:0] region;
        logic [7:0] rem;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] mx;
        logic [7:0] spread;
        logic [7:0] absdiff;
        logic       neg;
        t_sel       sel;
    } t_item;

    typedef struct packed {
        t_item       it;
        logic [15:0] sat_rem;
        logic [7:0]  sat_q;
        logic [13:0] hue_rem;
        logic [5:0]  hue_q;
        logic [7:0]  p;
        logic [7:0]  q;
        logic [7:0]  t;
        logic [7:0]  sr;
        logic [7:0]  srr;
    } t_work;

    typedef struct packed {
        logic [7:0] out_hue;
        logic [7:0] out_saturation;
        logic [7:0] out_value;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_result;

    typedef struct packed {
        logic avail;
        logic full;
    } t_qstat;

endpackage

[rtl/rhc_if.sv]
// rhc_if: valid/ready channel interfaces for the color converter
// input request channel and result channel; no dependencies
interface rhc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness_value;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, action, hue, saturation, brightness_value,
                    red, green, blue, input ready);
    modport sink   (input valid, action, hue, saturation, brightness_value,
                    red, green, blue, output ready);
endinterface

interface rhc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_hue;
    logic [7:0] out_saturation;
    logic [7:0] out_value;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, out_hue, out_saturation, out_value,
                    out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_hue, out_saturation, out_value,
                    out_red, out_green, out_blue, output ready);
endinterface

[rtl/rhc_front.sv]
// rhc_front: accepts requests and classifies them (hue region, max/min, spread)
// depends on rhc_pkg and rhc_in_if
module rhc_front
    import rhc_pkg::*;
(
    rhc_in_if.sink  i_in,
    input  t_qstat  i_qstat,
    output logic    o_push,
    output t_item   o_item
);

    logic [7:0] w_hbase;
    logic [7:0] w_off;
    logic [7:0] w_rem6;
    logic [7:0] w_mx;
    logic [7:0] w_mn;
    logic [7:0] w_da;
    logic [7:0] w_db;
    t_sel       w_sel;

    assign i_in.ready = !i_qstat.full;
    assign o_push     = i_in.valid && !i_qstat.full;

    always_comb begin
        o_item = '0;
        o_item.action = i_in.action;
        if (i_in.hue < 8'(HUE_SPAN)) begin
            o_item.region = 3'd0;
        end else if (i_in.hue < 8'(2 * HUE_SPAN)) begin
            o_item.region = 3'd1;
        end else if (i_in.hue < 8'(3 * HUE_SPAN)) begin
            o_item.region = 3'd2;
        end else if (i_in.hue < 8'(4 * HUE_SPAN)) begin
            o_item.region = 3'd3;
        end else if (i_in.hue < 8'(5 * HUE_SPAN)) begin
            o_item.region = 3'd4;
        end else begin
            o_item.region = 3'd5;
        end
        w_hbase = 8'(o_item.region * 8'(HUE_SPAN));
        w_off   = i_in.hue - w_hbase;
        w_rem6  = w_off * 8'(REGIONS);
        o_item.rem = w_rem6;
        o_item.sat = i_in.saturation;
        o_item.val = i_in.brightness_value;

        // red wins ties, then green
        if (i_in.red >= i_in.green && i_in.red >= i_in.blue) begin
            w_sel = SEL_RED;
            w_mx  = i_in.red;
            w_da  = i_in.green;
            w_db  = i_in.blue;
        end else if (i_in.green >= i_in.blue) begin
            w_sel = SEL_GREEN;
            w_mx  = i_in.green;
            w_da  = i_in.blue;
            w_db  = i_in.red;
        end else begin
            w_sel = SEL_BLUE;
            w_mx  = i_in.blue;
            w_da  = i_in.red;
            w_db  = i_in.green;
        end
        w_mn = i_in.red;
        if (i_in.green < w_mn) begin
            w_mn = i_in.green;
        end
        if (i_in.blue < w_mn) begin
            w_mn = i_in.blue;
        end
        o_item.sel     = w_sel;
        o_item.mx      = w_mx;
        o_item.spread  = w_mx - w_mn;
        o_item.neg     = w_da < w_db;
        o_item.absdiff = (w_da < w_db) ? (w_db - w_da) : (w_da - w_db);
    end

endmodule

[rtl/rhc_queue.sv]
// rhc_queue: short fifo of classified items between front and back
// depends on rhc_pkg
module rhc_queue
    import rhc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_head,
    output t_qstat o_qstat
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_cnt;
    logic [QAW-1:0]   n_wr;
    logic [QAW-1:0]   n_rd;
    logic [QAW:0]     n_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.avail = r_cnt != '0;
    assign o_qstat.full  = r_cnt == (QAW+1)'(QDEPTH);

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[rtl/rhc_back.sv]
// rhc_back: pipelined p/q/t products, restoring dividers and result assembly
// depends on rhc_pkg and rhc_out_if
module rhc_back
    import rhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_head,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    rhc_out_if.source   o_out
);

    t_work   r_pipe [PIPE_LAST+1];
    logic    r_pv   [PIPE_LAST+1];
    t_work   n_pipe [PIPE_LAST+1];
    t_result r_res;
    t_result n_res;
    logic    r_res_valid;
    logic    w_adv;
    logic [15:0] w_p;
    logic [15:0] w_sr;
    logic [15:0] w_srr;
    logic [15:0] w_q;
    logic [15:0] w_t;
    logic [7:0]  w_base;
    logic [7:0]  w_hq;
    t_work       w_last;

    assign w_adv = !r_res_valid || o_out.ready;
    assign o_pop = w_adv && i_qstat.avail;

    assign o_out.valid          = r_res_valid;
    assign o_out.out_hue        = r_res.out_hue;
    assign o_out.out_saturation = r_res.out_saturation;
    assign o_out.out_value      = r_res.out_value;
    assign o_out.out_red        = r_res.out_red;
    assign o_out.out_green      = r_res.out_green;
    assign o_out.out_blue       = r_res.out_blue;

    always_comb begin
        // stage 0: first products and divider setup
        w_p   = 16'(i_head.val) * 16'(8'hFF - i_head.sat);
        w_sr  = 16'(i_head.sat) * 16'(i_head.rem);
        w_srr = 16'(i_head.sat) * 16'(8'hFF - i_head.rem);
        n_pipe[0]         = '0;
        n_pipe[0].it      = i_head;
        n_pipe[0].sat_rem = 16'(i_head.spread) * 16'(255);
        n_pipe[0].hue_rem = 14'(i_head.absdiff) * 14'(HUE_SPAN);
        n_pipe[0].p       = w_p[15:8];
        n_pipe[0].sr      = w_sr[15:8];
        n_pipe[0].srr     = w_srr[15:8];

        // stages 1..last: one sat quotient bit each, q and t products in stage 1
        w_q = 16'(r_pipe[0].it.val) * 16'(8'hFF - r_pipe[0].sr);
        w_t = 16'(r_pipe[0].it.val) * 16'(8'hFF - r_pipe[0].srr);
        for (int i = 1; i <= PIPE_LAST; i++) begin
            n_pipe[i] = r_pipe[i-1];
            if (i == 1) begin
                n_pipe[i].q = w_q[15:8];
                n_pipe[i].t = w_t[15:8];
            end
            if (r_pipe[i-1].sat_rem >= (16'(r_pipe[i-1].it.mx) << (SAT_QW - i))) begin
                n_pipe[i].sat_rem = r_pipe[i-1].sat_rem
                                    - (16'(r_pipe[i-1].it.mx) << (SAT_QW - i));
                n_pipe[i].sat_q   = {r_pipe[i-1].sat_q[SAT_QW-2:0], 1'b1};
            end else begin
                n_pipe[i].sat_q   = {r_pipe[i-1].sat_q[SAT_QW-2:0], 1'b0};
            end
            if ((SAT_QW - i) < HUE_QW) begin
                if (r_pipe[i-1].hue_rem
                        >= (14'(r_pipe[i-1].it.spread) << (SAT_QW - i))) begin
                    n_pipe[i].hue_rem = r_pipe[i-1].hue_rem
                                        - (14'(r_pipe[i-1].it.spread) << (SAT_QW - i));
                    n_pipe[i].hue_q   = {r_pipe[i-1].hue_q[HUE_QW-2:0], 1'b1};
                end else begin
                    n_pipe[i].hue_q   = {r_pipe[i-1].hue_q[HUE_QW-2:0], 1'b0};
                end
            end
        end
    end

    // result assembly
    always_comb begin
        w_last = r_pipe[PIPE_LAST];
        n_res  = '0;
        w_hq   = 8'(w_last.hue_q);
        case (w_last.it.sel)
            SEL_RED:   w_base = 8'd0;
            SEL_GREEN: w_base = 8'(HUE_BASE_G);
            SEL_BLUE:  w_base = 8'(HUE_BASE_B);
            default:   w_base = 8'd0;
        endcase
        if (w_last.it.action == ACT_HSV2RGB) begin
            if (w_last.it.sat == 8'd0) begin
                n_res.out_red   = w_last.it.val;
                n_res.out_green = w_last.it.val;
                n_res.out_blue  = w_last.it.val;
            end else begin
                case (w_last.it.region)
                    3'd0: begin
                        n_res.out_red   = w_last.it.val;
                        n_res.out_green = w_last.t;
                        n_res.out_blue  = w_last.p;
                    end
                    3'd1: begin
                        n_res.out_red   = w_last.q;
                        n_res.out_green = w_last.it.val;
                        n_res.out_blue  = w_last.p;
                    end
                    3'd2: begin
                        n_res.out_red   = w_last.p;
                        n_res.out_green = w_last.it.val;
                        n_res.out_blue  = w_last.t;
                    end
                    3'd3: begin
                        n_res.out_red   = w_last.p;
                        n_res.out_green = w_last.q;
                        n_res.out_blue  = w_last.it.val;
                    end
                    3'd4: begin
                        n_res.out_red   = w_last.t;
                        n_res.out_green = w_last.p;
                        n_res.out_blue  = w_last.it.val;
                    end
                    default: begin
                        n_res.out_red   = w_last.it.val;
                        n_res.out_green = w_last.p;
                        n_res.out_blue  = w_last.q;
                    end
                endcase
            end
        end else begin
            n_res.out_value = w_last.it.mx;
            if (w_last.it.mx != 8'd0) begin
                n_res.out_saturation = w_last.sat_q;
                if (w_last.it.spread != 8'd0) begin
                    n_res.out_hue = w_last.it.neg ? (w_base - w_hq) : (w_base + w_hq);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            for (int i = 0; i <= PIPE_LAST; i++) begin
                r_pv[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_res_valid <= r_pv[PIPE_LAST];
            r_pv[0]     <= i_qstat.avail;
            for (int i = 1; i <= PIPE_LAST; i++) begin
                r_pv[i] <= r_pv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
            for (int i = 0; i <= PIPE_LAST; i++) begin
                r_pipe[i] <= n_pipe[i];
            end
        end
    end

endmodule

[rtl/rgb_hsv_color_converter_core.sv]
// rgb_hsv_color_converter_core: top level of the 8-bit rgb/hsv converter
// depends on rhc_pkg, rhc_if, rhc_front, rhc_queue and rhc_back
//
// One request gives one result. Requests are accepted every clock while
// the 4-entry queue has room; the back end takes one item per clock from
// the queue while the result sink is ready, so the sustained rate is one
// item per cycle. From acceptance to result valid an item passes through
// the queue register, a product stage and eight restoring divider stages
// (one saturation quotient bit each; hue bits in the later stages), then
// the result sits in the output register. When the result sink stalls the
// whole back pipeline holds, and the queue keeps accepting until it is full.
module rgb_hsv_color_converter_core
    import rhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhc_in_if.sink     i_in,
    rhc_out_if.source  o_out
);

    t_item  w_item;
    t_item  w_head;
    t_qstat w_qstat;
    logic   w_push;
    logic   w_pop;

    rhc_front u_front (
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_item  (w_item)
    );

    rhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    rhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qstat.avail)
        else $error("queue popped while empty");

    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !w_pop)
        else $error("queue popped while result stalled");

    a_unused_group_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.out_value != 8'd0))
            |-> (o_out.out_red == 8'd0 && o_out.out_green == 8'd0
                 && o_out.out_blue == 8'd0))
        else $error("both result groups nonzero");

endmodule

[dv/rgb_hsv_color_converter_core_tb.sv]
`timescale 1ns / 100ps
// rgb_hsv_color_converter_core_tb: self-checking bench for the 8-bit rgb/hsv converter
// drives a directed table then random conversions, checks every result against a table entry or a predictor
// depends on rhc_pkg, rhc_if and rgb_hsv_color_converter_core
module rgb_hsv_color_converter_core_tb;
    import rhc_pkg::*;

    localparam int N_DIRECTED     = 25;
    localparam int N_RANDOM       = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PRINTED    = 50;

    typedef struct packed {
        logic       action;
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] value;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       typed;
        t_result    res;
    } t_stim_row;

    // typed results are {hue, saturation, value, red, green, blue}
    localparam t_stim_row DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{ACT_HSV2RGB, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
          {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
        '{ACT_HSV2RGB, 8'd77,  8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 1'b1,
          {8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255}},
        '{ACT_HSV2RGB, 8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1,
          {8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}},
        '{ACT_HSV2RGB, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{ACT_HSV2RGB, 8'd42,  8'd200, 8'd180, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{ACT_HSV2RGB, 8'd43,  8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{ACT_HSV2RGB, 8'd86,  8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{ACT_HSV2RGB, 8'd129, 8'd128, 8'd200, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{ACT_HSV2RGB, 8'd172, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{ACT_HSV2RGB, 8'd215, 8'd1,   8'd255, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{ACT_HSV2RGB, 8'd100, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
          {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
        '{ACT_HSV2RGB, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{ACT_RGB2HSV, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1,
          {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b1,
          {8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0}},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   1'b1,
          {8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0}},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   1'b1,
          {8'd85, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0}},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 1'b1,
          {8'd171, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0}},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd100, 8'd100, 8'd100, 1'b1,
          {8'd0, 8'd0, 8'd100, 8'd0, 8'd0, 8'd0}},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd10,  1'b0, '0},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd200, 8'd200, 8'd10,  1'b0, '0},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd10,  8'd200, 8'd200, 1'b0, '0},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd200, 8'd10,  8'd200, 1'b0, '0},
        '{ACT_RGB2HSV, 8'd17,  8'd99,  8'd3,   8'd1,   8'd0,   8'd0,   1'b0, '0},
        '{ACT_RGB2HSV, 8'd0,   8'd0,   8'd0,   8'd30,  8'd20,  8'd25,  1'b0, '0},
        '{ACT_HSV2RGB, 8'd255, 8'd0,   8'd1,   8'd0,   8'd0,   8'd0,   1'b0, '0}
    };

    logic    i_clk;
    logic    i_rst_n;
    logic    quiet;
    int      err_count;
    int      idle_cycles;
    t_result pending_colors [$];
    string   field_names [6] = '{"out_hue", "out_saturation", "out_value",
                                 "out_red", "out_green", "out_blue"};

    rhc_in_if  in_ch ();
    rhc_out_if out_ch ();

    rgb_hsv_color_converter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result convert_color(input logic act, input logic [7:0] h, s, v,
                                              input logic [7:0] r, g, b);
        t_result res;
        int hi, si, vi, ri, gi, bi;
        int span, base_g, base_b;
        int region, rem, p, q, t, ro, go, bo;
        int mx, mn, spread, sat, hue;
        res    = '0;
        hi     = h;
        si     = s;
        vi     = v;
        ri     = r;
        gi     = g;
        bi     = b;
        span   = HUE_SPAN;
        base_g = HUE_BASE_G;
        base_b = HUE_BASE_B;
        if (act == ACT_HSV2RGB) begin
            if (si == 0) begin
                ro = vi;
                go = vi;
                bo = vi;
            end else begin
                region = hi / span;
                rem    = ((hi - region * span) * REGIONS) & 8'hFF;
                p      = (vi * (255 - si)) >> 8;
                q      = (vi * (255 - ((si * rem) >> 8))) >> 8;
                t      = (vi * (255 - ((si * (255 - rem)) >> 8))) >> 8;
                case (region)
                    0: begin ro = vi; go = t;  bo = p;  end
                    1: begin ro = q;  go = vi; bo = p;  end
                    2: begin ro = p;  go = vi; bo = t;  end
                    3: begin ro = p;  go = q;  bo = vi; end
                    4: begin ro = t;  go = p;  bo = vi; end
                    default: begin ro = vi; go = p; bo = q; end
                endcase
            end
            res.out_red   = ro[7:0];
            res.out_green = go[7:0];
            res.out_blue  = bo[7:0];
        end else begin
            mx = ri;
            mn = ri;
            if (gi > mx) mx = gi;
            if (bi > mx) mx = bi;
            if (gi < mn) mn = gi;
            if (bi < mn) mn = bi;
            res.out_value = mx[7:0];
            if (mx != 0) begin
                spread             = mx - mn;
                sat                = (255 * spread) / mx;
                res.out_saturation = sat[7:0];
                if (spread != 0) begin
                    if (mx == ri)
                        hue = (span * (gi - bi)) / spread;
                    else if (mx == gi)
                        hue = base_g + (span * (bi - ri)) / spread;
                    else
                        hue = base_b + (span * (ri - gi)) / spread;
                    res.out_hue = hue[7:0];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("ERROR %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic offer_color(input logic act, input logic [7:0] h, s, v, r, g, b,
                               input logic typed, input t_result typed_res);
        if (!quiet && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.action           <= act;
        in_ch.hue              <= h;
        in_ch.saturation       <= s;
        in_ch.brightness_value <= v;
        in_ch.red              <= r;
        in_ch.green            <= g;
        in_ch.blue             <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_colors.push_back(typed ? typed_res : convert_color(act, h, s, v, r, g, b));
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_colors.size() != 0);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // result side: stall at random unless quiet and compare each transaction with the oldest expected result
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge i_clk) begin
        logic [47:0] got_w;
        logic [47:0] exp_w;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got_w = {out_ch.out_hue, out_ch.out_saturation, out_ch.out_value,
                     out_ch.out_red, out_ch.out_green, out_ch.out_blue};
            if (pending_colors.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction %h", got_w));
            end else begin
                exp_w = pending_colors.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (got_w[47-8*k -: 8] !== exp_w[47-8*k -: 8])
                        report_mismatch($sformatf("%s got %0d expected %0d", field_names[k],
                                                  got_w[47-8*k -: 8], exp_w[47-8*k -: 8]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d transactions outstanding",
                     pending_colors.size());
            $display("FAIL rgb_hsv_color_converter_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic       act;
        logic [7:0] h, s, v, r, g, b;
        err_count              = 0;
        idle_cycles            = 0;
        quiet                  = 1'b0;
        i_rst_n                = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.action           = ACT_HSV2RGB;
        in_ch.hue              = '0;
        in_ch.saturation       = '0;
        in_ch.brightness_value = '0;
        in_ch.red              = '0;
        in_ch.green            = '0;
        in_ch.blue             = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_color(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].hue,
                        DIRECTED_ROWS[i].saturation, DIRECTED_ROWS[i].value,
                        DIRECTED_ROWS[i].red, DIRECTED_ROWS[i].green,
                        DIRECTED_ROWS[i].blue, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].res);
        end
        hold_until_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            // no idling on either side over this window
            if (i == 300) quiet <= 1'b1;
            if (i == 500) quiet <= 1'b0;
            if (i == 600) hold_until_drained();
            act = ($urandom_range(1) == 0) ? ACT_HSV2RGB : ACT_RGB2HSV;
            h   = pick_byte();
            s   = ($urandom_range(7) == 0) ? 8'd0 : pick_byte();
            v   = pick_byte();
            r   = pick_byte();
            g   = pick_byte();
            b   = pick_byte();
            // ties and grays
            case ($urandom_range(7))
                0: g = r;
                1: b = r;
                2: b = g;
                3: begin g = r; b = r; end
                default: ;
            endcase
            offer_color(act, h, s, v, r, g, b, 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS rgb_hsv_color_converter_core");
        else
            $display("FAIL rgb_hsv_color_converter_core");
        $finish;
    end

endmodule

[filelist.f]
rtl/rhc_pkg.sv
rtl/rhc_if.sv
rtl/rhc_front.sv
rtl/rhc_queue.sv
rtl/rhc_back.sv
rtl/rgb_hsv_color_converter_core.sv
dv/rgb_hsv_color_converter_core_tb.sv
